// ===== rtl/fwc_pkg.sv =====
// fwc_pkg: shared constants and types for the flash block write combiner
// depends on nothing; used by every module of the block except fwc_ram
package fwc_pkg;

  localparam int ADDR_W        = 22;
  localparam int BYTE_W        = 8;
  localparam int BYTE_OFFSET_W = 6;
  localparam int BLOCK_BYTES   = 64;
  localparam int OFF_W         = $clog2(BLOCK_BYTES);
  localparam int BASE_W        = ADDR_W - OFF_W;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  // one queued request: optional drain of the old block, then optional byte write
  typedef struct packed {
    logic              do_drain;
    logic [BASE_W-1:0] drain_base;
    logic              do_write;
    logic [OFF_W-1:0]  wr_off;
    logic [BYTE_W-1:0] wr_byte;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_WAIT = 4'b1000
  } back_state_t;

endpackage

// ===== rtl/flash_block_write_combiner.sv =====
// flash_block_write_combiner: top level, front classifier, request queue, drain engine
// depends on fwc_pkg, fwc_front, fwc_queue, fwc_back (and fwc_ram through fwc_back)
//
// usage:
//   in_ channel: a request is a byte write (in_command low) or a flush and retarget
//   (in_command high) at in_address. writes gather in a 64-byte aligned block buffer.
//   out_ channel: a write outside the current block or a flush, when the buffer holds
//   written data, produces 64 results in offset order, the last one marked.
//   flow: a request is taken whenever the 4-entry queue has room;
//   the back end writes a plain write to the ram as it picks up the request, and
//   takes each drained byte through ram read, output load and handoff, reading the
//   next byte only after the handoff, since the buffer ram has a single read port
//   and the output register is one deep.
//   a stalled receiver holds the drain at its current byte; the front keeps taking
//   requests until the queue fills, then drops in_ready.
//   reset: synchronous, active low; the buffer reads as all 0xFF at once (per-byte
//   valid bits), block base goes to zero and nothing counts as written.
module flash_block_write_combiner (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [fwc_pkg::ADDR_W-1:0]        in_address,
  input  logic [fwc_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fwc_pkg::ADDR_W-1:0]        out_block_address,
  output logic [fwc_pkg::BYTE_OFFSET_W-1:0] out_byte_offset,
  output logic [fwc_pkg::BYTE_W-1:0]        out_out_byte,
  output logic                              out_last_of_block
);

  logic         push, q_full, q_empty, pop;
  fwc_pkg::op_t push_op, head;

  fwc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_address  (in_address),
    .in_data_byte(in_data_byte),
    .push        (push),
    .push_op     (push_op),
    .q_full      (q_full)
  );

  fwc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_op(push_op),
    .full   (q_full),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty)
  );

  fwc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_block_address(out_block_address),
    .out_byte_offset  (out_byte_offset),
    .out_out_byte     (out_out_byte),
    .out_last_of_block(out_last_of_block)
  );

endmodule

// ===== rtl/fwc_ram.sv =====
// fwc_ram: generic single write port, single read port ram with registered read
// depends on nothing
module fwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fwc_queue.sv =====
// fwc_queue: short register queue of op_t requests between front and back
// depends on fwc_pkg
module fwc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fwc_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output fwc_pkg::op_t  head,
  output logic          empty
);

  fwc_pkg::op_t                q_r [fwc_pkg::QDEPTH];
  logic [fwc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [fwc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [fwc_pkg::QPTR_W:0]    count_r, count_nxt;
  logic                        do_push, do_pop;

  assign full    = (count_r == (fwc_pkg::QPTR_W+1)'(fwc_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/fwc_front.sv =====
// fwc_front: accepts requests, tracks block base and dirty flag, queues the work
// depends on fwc_pkg
module fwc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [fwc_pkg::ADDR_W-1:0] in_address,
  input  logic [fwc_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       push,
  output fwc_pkg::op_t               push_op,
  input  logic                       q_full
);

  logic [fwc_pkg::BASE_W-1:0] base_r, base_nxt;
  logic                       dirty_r, dirty_nxt;
  logic                       accept, same_blk, leave;
  logic [fwc_pkg::BASE_W-1:0] addr_hi;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign addr_hi  = in_address[fwc_pkg::ADDR_W-1:fwc_pkg::OFF_W];
  // base stays aligned, so the block test is a compare of the upper bits
  assign same_blk = (addr_hi == base_r);
  assign leave    = in_command | ~same_blk;

  always_comb begin
    push_op.do_drain   = leave & dirty_r;
    push_op.drain_base = base_r;
    push_op.do_write   = ~in_command;
    push_op.wr_off     = in_address[fwc_pkg::OFF_W-1:0];
    push_op.wr_byte    = in_data_byte;
    push     = accept & (push_op.do_drain | push_op.do_write);
    base_nxt = (accept & leave) ? addr_hi : base_r;
    // a write leaves the buffer dirty, a flush leaves it clean
    dirty_nxt = accept ? ~in_command : dirty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      dirty_r <= 1'b0;
    end else begin
      base_r  <= base_nxt;
      dirty_r <= dirty_nxt;
    end
  end

endmodule

// ===== rtl/fwc_back.sv =====
// fwc_back: executes queued requests on the block buffer and drains blocks
// depends on fwc_pkg and fwc_ram
module fwc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fwc_pkg::op_t                      head,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fwc_pkg::ADDR_W-1:0]        out_block_address,
  output logic [fwc_pkg::BYTE_OFFSET_W-1:0] out_byte_offset,
  output logic [fwc_pkg::BYTE_W-1:0]        out_out_byte,
  output logic                              out_last_of_block
);

  fwc_pkg::back_state_t state_r, state_nxt;
  logic [fwc_pkg::OFF_W-1:0]         cnt_r, cnt_nxt;
  logic [fwc_pkg::BLOCK_BYTES-1:0]   valid_r, valid_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [fwc_pkg::ADDR_W-1:0]        out_addr_r, out_addr_nxt;
  logic [fwc_pkg::BYTE_OFFSET_W-1:0] out_off_r, out_off_nxt;
  logic [fwc_pkg::BYTE_W-1:0]        out_byte_r, out_byte_nxt;
  logic                              out_last_r, out_last_nxt;
  logic                              ram_we, ram_re;
  logic [fwc_pkg::BYTE_W-1:0]        ram_rdata;
  logic                              last_byte;

  assign last_byte = (cnt_r == fwc_pkg::OFF_W'(fwc_pkg::BLOCK_BYTES - 1));

  fwc_ram #(
    .WIDTH(fwc_pkg::BYTE_W),
    .DEPTH(fwc_pkg::BLOCK_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head.wr_off),
    .wdata(head.wr_byte),
    .re   (ram_re),
    .raddr(cnt_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_off_nxt   = out_off_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    pop           = 1'b0;
    case (state_r)
      fwc_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (head.do_drain) begin
            cnt_nxt   = '0;
            state_nxt = fwc_pkg::ST_READ;
          end else begin
            ram_we                 = head.do_write;
            valid_nxt[head.wr_off] = valid_r[head.wr_off] | head.do_write;
            pop                    = 1'b1;
          end
        end
      end
      fwc_pkg::ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = fwc_pkg::ST_LOAD;
      end
      fwc_pkg::ST_LOAD: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = {head.drain_base, {fwc_pkg::OFF_W{1'b0}}};
        out_off_nxt   = fwc_pkg::BYTE_OFFSET_W'(cnt_r);
        // entries never written since the last drain read as erased
        out_byte_nxt  = valid_r[cnt_r] ? ram_rdata : fwc_pkg::ERASED_BYTE;
        out_last_nxt  = last_byte;
        state_nxt     = fwc_pkg::ST_WAIT;
      end
      fwc_pkg::ST_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_byte) begin
            // clear every valid bit so all bytes read as erased, then apply the write, if any, that caused the drain
            valid_nxt              = '0;
            valid_nxt[head.wr_off] = head.do_write;
            ram_we                 = head.do_write;
            pop                    = 1'b1;
            state_nxt              = fwc_pkg::ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = fwc_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = fwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fwc_pkg::ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_off_r  <= out_off_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_byte_offset   = out_off_r;
  assign out_out_byte      = out_byte_r;
  assign out_last_of_block = out_last_r;

  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == fwc_pkg::ST_WAIT))
    else $error("result shown outside the wait state");

  a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_off_r == fwc_pkg::BYTE_OFFSET_W'(fwc_pkg::BLOCK_BYTES - 1)))
    else $error("last of block marked on a wrong offset");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwc_pkg::ST_LOAD) |=> out_valid_r)
    else $error("loaded result not shown");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from an empty queue");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register lost its one-hot code");

endmodule

// ===== verif/tb_flash_block_write_combiner.sv =====
// testbench for flash_block_write_combiner: byte writes and flushes in random bursts,
// every drained byte checked against a shadow copy of the block buffer
// depends on fwc_pkg and the flash_block_write_combiner rtl
`timescale 1ns / 1ps

module tb_flash_block_write_combiner;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 84;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SLOW,
    RX_RARE
  } rx_mode_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [fwc_pkg::ADDR_W-1:0] addr;
    logic [fwc_pkg::BYTE_W-1:0] data;
  } flash_req_t;

  typedef struct packed {
    logic [fwc_pkg::ADDR_W-1:0]        blk;
    logic [fwc_pkg::BYTE_OFFSET_W-1:0] off;
    logic [fwc_pkg::BYTE_W-1:0]        data;
    logic                              last;
  } drain_byte_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_command = 1'b0;
  logic [fwc_pkg::ADDR_W-1:0]        in_address = '0;
  logic [fwc_pkg::BYTE_W-1:0]        in_data_byte = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [fwc_pkg::ADDR_W-1:0]        out_block_address;
  logic [fwc_pkg::BYTE_OFFSET_W-1:0] out_byte_offset;
  logic [fwc_pkg::BYTE_W-1:0]        out_out_byte;
  logic                              out_last_of_block;

  flash_req_t  pending_reqs[$];
  drain_byte_t expected_bytes[$];

  // shadow of the block buffer
  logic [fwc_pkg::BYTE_W-1:0] shadow_buf[fwc_pkg::BLOCK_BYTES];
  logic [fwc_pkg::ADDR_W-1:0] shadow_base;
  logic                       shadow_dirty;

  flash_req_t cur_req = '0;
  int burst_left = 0;
  int gap_left = 0;
  int n_total = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int idle_cycles = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  flash_block_write_combiner DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_address (out_block_address),
    .out_byte_offset   (out_byte_offset),
    .out_out_byte      (out_out_byte),
    .out_last_of_block (out_last_of_block)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void apply_request(input flash_req_t r);
    logic                       in_block;
    logic [fwc_pkg::ADDR_W-1:0] rel;
    drain_byte_t                d;
    int                         k;
    in_block = (r.addr >= shadow_base) &&
               ((r.addr - shadow_base) < fwc_pkg::BLOCK_BYTES);
    if (r.cmd == CMD_FLUSH || !in_block) begin
      if (shadow_dirty) begin
        for (k = 0; k < fwc_pkg::BLOCK_BYTES; k++) begin
          d.blk  = shadow_base;
          d.off  = fwc_pkg::BYTE_OFFSET_W'(k);
          d.data = shadow_buf[k];
          d.last = (k == fwc_pkg::BLOCK_BYTES - 1);
          expected_bytes.push_back(d);
          shadow_buf[k] = fwc_pkg::ERASED_BYTE;
        end
        shadow_dirty = 1'b0;
      end
      shadow_base = fwc_pkg::ADDR_W'((r.addr / fwc_pkg::BLOCK_BYTES) * fwc_pkg::BLOCK_BYTES);
      if (r.cmd == CMD_FLUSH) return;
    end
    rel = r.addr - shadow_base;
    if (rel < fwc_pkg::BLOCK_BYTES) begin
      shadow_buf[rel[fwc_pkg::OFF_W-1:0]] = r.data;
      shadow_dirty = 1'b1;
    end
  endfunction

  function automatic void note_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  task automatic push_req(input cmd_t cmd, input logic [fwc_pkg::ADDR_W-1:0] addr,
                          input logic [fwc_pkg::BYTE_W-1:0] data);
    flash_req_t r;
    r.cmd  = cmd;
    r.addr = addr;
    r.data = data;
    pending_reqs.push_back(r);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(posedge clk) begin : tx
    logic offer;
    if (rst_n) begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        apply_request(cur_req);
        n_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid     <= offer;
      in_command   <= cur_req.cmd;
      in_address   <= cur_req.addr;
      in_data_byte <= cur_req.data;
    end
  end

  // receiver: check each drained byte, stall on a changing pattern
  always @(posedge clk) begin : rx
    drain_byte_t got;
    drain_byte_t want;
    logic        nxt_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.blk  = out_block_address;
        got.off  = out_byte_offset;
        got.data = out_out_byte;
        got.last = out_last_of_block;
        n_results++;
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte blk=%h off=%0d data=%h last=%b",
                               got.blk, got.off, got.data, got.last));
        end else begin
          want = expected_bytes.pop_front();
          if (got.blk !== want.blk || got.off !== want.off ||
              got.data !== want.data || got.last !== want.last)
            note_error($sformatf(
              "exp blk=%h off=%0d data=%h last=%b, got blk=%h off=%0d data=%h last=%b",
              want.blk, want.off, want.data, want.last,
              got.blk, got.off, got.data, got.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (!hold_done && out_valid && n_results >= fwc_pkg::BLOCK_BYTES &&
                   pending_reqs.size() > 4) begin
        // long hold-off mid drain so the request queue backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        nxt_ready = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 150);
        end else begin
          rx_left--;
        end
        case (rx_mode)
          RX_OPEN: nxt_ready = 1'b1;
          RX_COIN: nxt_ready = 1'($urandom_range(0, 1));
          RX_SLOW: nxt_ready = (rx_phase % 4 == 0);
          default: nxt_ready = ($urandom_range(0, 7) != 0);
        endcase
        rx_phase++;
      end
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [fwc_pkg::ADDR_W-1:0] hot[4];
    logic [fwc_pkg::ADDR_W-1:0] base;
    logic [5:0]                 off;
    int                         n_rand;
    int                         n_wr;
    int                         i;

    for (i = 0; i < fwc_pkg::BLOCK_BYTES; i++) shadow_buf[i] = fwc_pkg::ERASED_BYTE;
    shadow_base  = '0;
    shadow_dirty = 1'b0;

    // directed: first write at address 0, repeats, field extremes, clean flushes
    push_req(CMD_WRITE, 22'h000000, 8'h00);
    push_req(CMD_WRITE, 22'h000005, 8'h11);
    push_req(CMD_WRITE, 22'h000005, 8'h22);
    push_req(CMD_WRITE, 22'h00003F, 8'hFF);
    push_req(CMD_WRITE, 22'h3FFFFF, 8'hA5);
    push_req(CMD_WRITE, 22'h3FFFC0, 8'h5A);
    push_req(CMD_FLUSH, 22'h2AAAAA, 8'hC3);
    push_req(CMD_FLUSH, 22'h155555, 8'h3C);
    push_req(CMD_WRITE, 22'h2AAAAA, 8'h96);
    push_req(CMD_WRITE, 22'h155555, 8'h69);
    push_req(CMD_FLUSH, 22'h000000, 8'hFF);
    push_req(CMD_FLUSH, 22'h3FFFFF, 8'h00);
    push_req(CMD_WRITE, 22'h000040, 8'h01);
    push_req(CMD_WRITE, 22'h00007F, 8'h80);
    push_req(CMD_WRITE, 22'h000080, 8'h7F);
    push_req(CMD_FLUSH, 22'h000081, 8'hAA);

    // random: mostly fill sequences on a few recurring blocks, some noise
    for (i = 0; i < 4; i++)
      hot[i] = fwc_pkg::ADDR_W'($urandom_range(0, 22'h3FFFFF)) & ~22'h3F;
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        base = ($urandom_range(0, 2) == 0) ?
               (fwc_pkg::ADDR_W'($urandom_range(0, 22'h3FFFFF)) & ~22'h3F) :
               hot[2'($urandom_range(0, 3))];
        n_wr = $urandom_range(1, 10);
        off = 6'($urandom_range(0, 63));
        for (i = 0; i < n_wr; i++) begin
          if ($urandom_range(0, 9) >= 3) off = 6'($urandom_range(0, 63));
          push_req(CMD_WRITE, base | fwc_pkg::ADDR_W'(off), 8'($urandom_range(0, 255)));
          n_rand++;
        end
        case ($urandom_range(0, 2))
          0: begin
            push_req(CMD_FLUSH, fwc_pkg::ADDR_W'($urandom_range(0, 22'h3FFFFF)),
                     8'($urandom_range(0, 255)));
            n_rand++;
          end
          1: begin
            // flush that lands inside the same block
            push_req(CMD_FLUSH, base | fwc_pkg::ADDR_W'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
            n_rand++;
          end
          default: ;
        endcase
      end else begin
        push_req(cmd_t'($urandom_range(0, 1)),
                 fwc_pkg::ADDR_W'($urandom_range(0, 22'h3FFFFF)),
                 8'($urandom_range(0, 255)));
        n_rand++;
      end
    end
    n_total = pending_reqs.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== flash_block_write_combiner.f =====
rtl/fwc_pkg.sv
rtl/fwc_ram.sv
rtl/fwc_queue.sv
rtl/fwc_front.sv
rtl/fwc_back.sv
rtl/flash_block_write_combiner.sv
verif/tb_flash_block_write_combiner.sv
